// File: hw/rtl/kpzss_pkg.sv
package kpzss_pkg;

  // Lattice shape defaults
  localparam int COLUMN_BITS_DEFAULT = 10;
  localparam int ROW_BITS_DEFAULT    = 6;

  localparam int CHANCE_W   = 16;
  localparam int PROB_W     = 17;
  localparam int MODE_W     = 2;
  localparam int REQ_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = PROB_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Update modes; bit 1 selects the disorder-driven probabilities
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam int                MODE_DISORDER_BIT = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_P_ZERO = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_Q_ZERO = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_P_ONE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_Q_ONE  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_PLAIN;
  localparam logic [PROB_W-1:0] PROB_RESET = 17'h10000;

  // Slope pair {right, here}
  localparam logic [1:0] PAIR_P = 2'b10;
  localparam logic [1:0] PAIR_Q = 2'b01;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PROB_W-1:0] p_zero;
    logic [PROB_W-1:0] q_zero;
    logic [PROB_W-1:0] p_one;
    logic [PROB_W-1:0] q_one;
  } cfg_t;

endpackage

// File: hw/rtl/kpzss_bit_ram.sv
module kpzss_bit_ram #(
  parameter int ADDR_W = 15
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/kpzss_flip_rule.sv
module kpzss_flip_rule (
  input  kpzss_pkg::cfg_t                     cfg,
  input  logic                                here_slope,
  input  logic                                right_slope,
  input  logic                                here_disorder,
  input  logic [kpzss_pkg::CHANCE_W-1:0]      chance,
  output logic                                flip
);

  logic [1:0]                      pair;
  logic                            use_one;
  logic [kpzss_pkg::PROB_W-1:0]    prob_p;
  logic [kpzss_pkg::PROB_W-1:0]    prob_q;
  logic [kpzss_pkg::PROB_W-1:0]    chance_ext;

  assign pair       = {right_slope, here_slope};
  assign use_one    = cfg.mode[kpzss_pkg::MODE_DISORDER_BIT] & here_disorder;
  assign prob_p     = use_one ? cfg.p_one : cfg.p_zero;
  assign prob_q     = use_one ? cfg.q_one : cfg.q_zero;
  assign chance_ext = {1'b0, chance};

  always_comb begin
    flip = 1'b0;
    if (cfg.mode == kpzss_pkg::MODE_PLAIN) begin
      flip = (pair == kpzss_pkg::PAIR_P);
    end else begin
      case (pair)
        kpzss_pkg::PAIR_P: flip = (chance_ext < prob_p);
        kpzss_pkg::PAIR_Q: flip = (chance_ext < prob_q);
        default:           flip = 1'b0;
      endcase
    end
  end

endmodule

// File: hw/rtl/kpz_single_step_site_update_core.sv
// Flow: a word taken in IDLE is held and its stores are read on acceptance; in READ,
//   once the result register is free, it is resolved, written back and registered.
// The input stalls until the held word has been written back to the slope banks.
// Reset: clears the handshake state and loads the registers with their reset values;
//   the slope and disorder stores are not cleared and hold nothing until loaded.
module kpz_single_step_site_update_core #(
  parameter int COLUMN_BITS = kpzss_pkg::COLUMN_BITS_DEFAULT,
  parameter int ROW_BITS    = kpzss_pkg::ROW_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [kpzss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kpzss_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kpzss_pkg::REQ_W-1:0]         req_type,
  input  logic [COLUMN_BITS-1:0]              column,
  // a lattice with no row bits still carries a one-bit row port; that bit is ignored
  input  logic [((ROW_BITS > 0) ? ROW_BITS : 1)-1:0] row,
  input  logic [kpzss_pkg::CHANCE_W-1:0]      chance,
  input  logic                                load_slope,
  input  logic                                load_disorder,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                site_slope,
  output logic                                site_disorder,
  output logic                                did_flip
);

  localparam int SiteW    = COLUMN_BITS + ROW_BITS;
  localparam int BankW    = SiteW - 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  kpzss_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= kpzss_pkg::MODE_RESET;
      cfg.p_zero <= kpzss_pkg::PROB_RESET;
      cfg.q_zero <= kpzss_pkg::PROB_RESET;
      cfg.p_one  <= kpzss_pkg::PROB_RESET;
      cfg.q_one  <= kpzss_pkg::PROB_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kpzss_pkg::CFG_MODE:   cfg.mode   <= cfg_data[kpzss_pkg::MODE_W-1:0];
        kpzss_pkg::CFG_P_ZERO: cfg.p_zero <= cfg_data;
        kpzss_pkg::CFG_Q_ZERO: cfg.q_zero <= cfg_data;
        kpzss_pkg::CFG_P_ONE:  cfg.p_one  <= cfg_data;
        kpzss_pkg::CFG_Q_ONE:  cfg.q_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Site addressing
  // The slope store is split by column parity into two banks, so a site and
  // its right-hand neighbour always sit in different banks and can be read and
  // written back together. A bank address is the site index without the
  // column LSB. Bank 1 always uses the named site's address: for an even
  // column its neighbour shares it. Bank 0 uses the neighbour's address when
  // the column is odd.
  // ---------------------------------------------------------------------------
  logic [COLUMN_BITS-1:0] column_right;
  logic [SiteW-1:0]       site_here;
  logic [SiteW-1:0]       site_right;
  logic [BankW-1:0]       bank0_rd_addr;
  logic [BankW-1:0]       bank1_rd_addr;

  assign column_right  = column + COLUMN_BITS'(1);
  // with no row bits the shift pushes the row out entirely
  assign site_here     = (SiteW'(row) << COLUMN_BITS) | SiteW'(column);
  assign site_right    = (SiteW'(row) << COLUMN_BITS) | SiteW'(column_right);
  assign bank1_rd_addr = site_here[SiteW-1:1];
  assign bank0_rd_addr = column[0] ? site_right[SiteW-1:1] : site_here[SiteW-1:1];

  // ---------------------------------------------------------------------------
  // Control: take a word in IDLE, resolve it in READ once the result register
  // is free, then drop back to IDLE. Writes happen only in READ, reads only on
  // acceptance, so a read never overlaps a pending write to the same entry.
  // ---------------------------------------------------------------------------
  logic state;
  logic state_next;
  logic accept;
  logic commit;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state == ST_READ) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted word for the write-back cycle
  logic [kpzss_pkg::REQ_W-1:0]    req;
  logic                           odd_column;
  logic [kpzss_pkg::CHANCE_W-1:0] chance_held;
  logic                           slope_in;
  logic                           disorder_in;
  logic [SiteW-1:0]               site;
  logic [BankW-1:0]               bank0_addr;
  logic [BankW-1:0]               bank1_addr;

  always_ff @(posedge clk) begin
    if (accept) begin
      req         <= req_type;
      odd_column  <= column[0];
      chance_held <= chance;
      slope_in    <= load_slope;
      disorder_in <= load_disorder;
      site        <= site_here;
      bank0_addr  <= bank0_rd_addr;
      bank1_addr  <= bank1_rd_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  logic bank0_rd;
  logic bank1_rd;
  logic disorder_rd;
  logic bank0_wr_en;
  logic bank1_wr_en;
  logic disorder_wr_en;
  logic bank0_wr_data;
  logic bank1_wr_data;

  kpzss_bit_ram #(.ADDR_W(BankW)) u_slope_even (
    .clk     (clk),
    .wr_en   (bank0_wr_en),
    .wr_addr (bank0_addr),
    .wr_data (bank0_wr_data),
    .rd_en   (accept),
    .rd_addr (bank0_rd_addr),
    .rd_data (bank0_rd)
  );

  kpzss_bit_ram #(.ADDR_W(BankW)) u_slope_odd (
    .clk     (clk),
    .wr_en   (bank1_wr_en),
    .wr_addr (bank1_addr),
    .wr_data (bank1_wr_data),
    .rd_en   (accept),
    .rd_addr (bank1_rd_addr),
    .rd_data (bank1_rd)
  );

  kpzss_bit_ram #(.ADDR_W(SiteW)) u_disorder (
    .clk     (clk),
    .wr_en   (disorder_wr_en),
    .wr_addr (site),
    .wr_data (disorder_in),
    .rd_en   (accept),
    .rd_addr (site_here),
    .rd_data (disorder_rd)
  );

  // ---------------------------------------------------------------------------
  // Resolve the held word
  // ---------------------------------------------------------------------------
  logic is_load;
  logic is_update;
  logic here_slope;
  logic right_slope;
  logic rule_flip;
  logic flip;

  assign is_load     = (req == kpzss_pkg::REQ_LOAD);
  assign is_update   = (req == kpzss_pkg::REQ_UPDATE);
  assign here_slope  = odd_column ? bank1_rd : bank0_rd;
  assign right_slope = odd_column ? bank0_rd : bank1_rd;

  kpzss_flip_rule u_rule (
    .cfg           (cfg),
    .here_slope    (here_slope),
    .right_slope   (right_slope),
    .here_disorder (disorder_rd),
    .chance        (chance_held),
    .flip          (rule_flip)
  );

  assign flip = is_update && rule_flip;

  // A flip inverts both bits of the pair, one in each bank; a load writes the
  // named site's bank only.
  always_comb begin
    bank0_wr_en    = 1'b0;
    bank1_wr_en    = 1'b0;
    bank0_wr_data  = ~bank0_rd;
    bank1_wr_data  = ~bank1_rd;
    disorder_wr_en = 1'b0;
    if (commit) begin
      if (is_load) begin
        bank0_wr_en    = !odd_column;
        bank1_wr_en    = odd_column;
        bank0_wr_data  = slope_in;
        bank1_wr_data  = slope_in;
        disorder_wr_en = 1'b1;
      end else if (flip) begin
        bank0_wr_en = 1'b1;
        bank1_wr_en = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      site_slope    <= is_load ? slope_in : (here_slope ^ flip);
      site_disorder <= is_load ? disorder_in : disorder_rd;
      did_flip      <= flip;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_to_read : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_READ))
    else $error("accepted word did not move to the read state");

  a_write_in_commit : assert property (@(posedge clk) disable iff (rst)
    (bank0_wr_en || bank1_wr_en || disorder_wr_en) |-> commit)
    else $error("store written outside the write-back cycle");

  a_flip_update_only : assert property (@(posedge clk) disable iff (rst)
    (commit && flip) |-> (is_update && bank0_wr_en && bank1_wr_en && !disorder_wr_en))
    else $error("flip without an update attempt writing both banks");

  a_commit_loads_out : assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("resolved word not presented on the result channel");

endmodule

// File: test/kpz_site_word_checker.sv
`timescale 1ns / 1ps

module kpz_site_word_checker #(
  parameter int COLUMN_BITS = kpzss_pkg::COLUMN_BITS_DEFAULT,
  parameter int ROW_BITS    = kpzss_pkg::ROW_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [kpzss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kpzss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [kpzss_pkg::REQ_W-1:0]       req_type,
  input  logic [COLUMN_BITS-1:0]            column,
  input  logic [ROW_BITS-1:0]               row,
  input  logic [kpzss_pkg::CHANCE_W-1:0]    chance,
  input  logic                              load_slope,
  input  logic                              load_disorder,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              site_slope,
  input  logic                              site_disorder,
  input  logic                              did_flip,
  output int                                mismatch_count,
  output int                                words_pending
);

  localparam int SITE_BITS = COLUMN_BITS + ROW_BITS;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [SITE_BITS-1:0] site;
    logic                 slope;
    logic                 disorder;
    logic                 flip;
  } site_word_t;

  kpzss_pkg::cfg_t lattice_cfg;
  bit         slope_bits    [0:(1 << SITE_BITS)-1];
  bit         disorder_bits [0:(1 << SITE_BITS)-1];
  site_word_t words_due [$];
  site_word_t due;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    // keep the log readable when a design is badly broken
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] site word mismatch: %s", $time, what);
  endtask

  // Apply one request to the lattice copy and return the word it should produce.
  function automatic site_word_t step_lattice(
    input logic [kpzss_pkg::REQ_W-1:0]    rq,
    input logic [COLUMN_BITS-1:0]         col,
    input logic [ROW_BITS-1:0]            rw,
    input logic [kpzss_pkg::CHANCE_W-1:0] ch,
    input logic                           ls,
    input logic                           ld
  );
    logic [COLUMN_BITS-1:0]         col_next;
    logic [SITE_BITS-1:0]           here;
    logic [SITE_BITS-1:0]           right;
    logic [1:0]                     pair;
    logic                           dis;
    logic [kpzss_pkg::PROB_W-1:0]   p;
    logic [kpzss_pkg::PROB_W-1:0]   q;
    site_word_t                     w;
    col_next = col + COLUMN_BITS'(1);
    here     = {rw, col};
    right    = {rw, col_next};
    w.site   = here;
    w.flip   = 1'b0;
    if (rq == kpzss_pkg::REQ_LOAD) begin
      slope_bits[here]    = ls;
      disorder_bits[here] = ld;
    end else if (rq == kpzss_pkg::REQ_UPDATE) begin
      pair = {slope_bits[right], slope_bits[here]};
      if (lattice_cfg.mode == kpzss_pkg::MODE_PLAIN) begin
        w.flip = (pair == kpzss_pkg::PAIR_P);
      end else begin
        dis = lattice_cfg.mode[kpzss_pkg::MODE_DISORDER_BIT] ? disorder_bits[here] : 1'b0;
        p   = dis ? lattice_cfg.p_one : lattice_cfg.p_zero;
        q   = dis ? lattice_cfg.q_one : lattice_cfg.q_zero;
        if (pair == kpzss_pkg::PAIR_P)
          w.flip = ({1'b0, ch} < p);
        else if (pair == kpzss_pkg::PAIR_Q)
          w.flip = ({1'b0, ch} < q);
      end
      if (w.flip) begin
        slope_bits[here]  = ~slope_bits[here];
        slope_bits[right] = ~slope_bits[right];
      end
    end
    w.slope    = slope_bits[here];
    w.disorder = disorder_bits[here];
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      lattice_cfg <= '{mode: kpzss_pkg::MODE_RESET, p_zero: kpzss_pkg::PROB_RESET,
                       q_zero: kpzss_pkg::PROB_RESET, p_one: kpzss_pkg::PROB_RESET,
                       q_one: kpzss_pkg::PROB_RESET};
      words_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          kpzss_pkg::CFG_MODE:   lattice_cfg.mode   <= cfg_data[kpzss_pkg::MODE_W-1:0];
          kpzss_pkg::CFG_P_ZERO: lattice_cfg.p_zero <= cfg_data;
          kpzss_pkg::CFG_Q_ZERO: lattice_cfg.q_zero <= cfg_data;
          kpzss_pkg::CFG_P_ONE:  lattice_cfg.p_one  <= cfg_data;
          kpzss_pkg::CFG_Q_ONE:  lattice_cfg.q_one  <= cfg_data;
          default: ;
        endcase
      end
      // retire before predicting: a word cannot answer a request taken at the same edge
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing due (slope %b disorder %b flip %b)",
                                    site_slope, site_disorder, did_flip));
        end else begin
          due = words_due.pop_front();
          if (site_slope !== due.slope || site_disorder !== due.disorder ||
              did_flip !== due.flip)
            report_mismatch($sformatf(
              "row %0d col %0d: got slope %b disorder %b flip %b, want %b %b %b",
              due.site[SITE_BITS-1:COLUMN_BITS], due.site[COLUMN_BITS-1:0],
              site_slope, site_disorder, did_flip, due.slope, due.disorder, due.flip));
        end
      end
      if (in_valid && !in_stall)
        words_due.push_back(step_lattice(req_type, column, row, chance,
                                         load_slope, load_disorder));
    end
    words_pending <= words_due.size();
  end

endmodule

// File: test/tb_kpz_single_step_site_update_core.sv
`timescale 1ns / 1ps

module tb_kpz_single_step_site_update_core;

  localparam int COLUMN_BITS = kpzss_pkg::COLUMN_BITS_DEFAULT;
  localparam int ROW_BITS    = kpzss_pkg::ROW_BITS_DEFAULT;
  localparam int SITE_BITS   = COLUMN_BITS + ROW_BITS;
  localparam int REQ_W       = kpzss_pkg::REQ_W;
  localparam int MODE_W      = kpzss_pkg::MODE_W;
  localparam int PROB_W      = kpzss_pkg::PROB_W;
  localparam int CHANCE_W    = kpzss_pkg::CHANCE_W;
  localparam int CFG_DATA_W  = kpzss_pkg::CFG_DATA_W;

  // Request code outside the documented set; the block treats it as a read
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Update modes beyond plain, as the checker and the block decode them
  localparam logic [MODE_W-1:0] MODE_PQ       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISORDER = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd3;

  localparam logic [PROB_W-1:0] PROB_ALWAYS = 17'h10000;
  localparam logic [PROB_W-1:0] PROB_NEVER  = 17'h00000;
  localparam logic [PROB_W-1:0] PROB_HUGE   = 17'h1FFFF;

  localparam int PHASE_WORDS  = 205;
  localparam int HOLD_CYCLES  = 300;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [kpzss_pkg::CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]               cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic [REQ_W-1:0]                    req_type;
  logic [COLUMN_BITS-1:0]              column;
  logic [ROW_BITS-1:0]                 row;
  logic [CHANCE_W-1:0]                 chance;
  logic                                load_slope;
  logic                                load_disorder;
  logic                                out_valid;
  logic                                out_stall;
  logic                                site_slope;
  logic                                site_disorder;
  logic                                did_flip;
  int                                  mismatch_count;
  int                                  words_pending;

  // Stimulus bookkeeping: which sites hold defined bits, and the live settings
  bit                     site_loaded [0:(1 << SITE_BITS)-1];
  logic [SITE_BITS-1:0]   loaded_sites [$];
  kpzss_pkg::cfg_t        lattice_settings;
  int unsigned            words_sent;
  int unsigned            burst_left;
  int                     hold_off_asks;
  int                     hold_off_done;

  kpz_single_step_site_update_core #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .column       (column),
    .row          (row),
    .chance       (chance),
    .load_slope   (load_slope),
    .load_disorder(load_disorder),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .site_slope   (site_slope),
    .site_disorder(site_disorder),
    .did_flip     (did_flip)
  );

  kpz_site_word_checker #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) watch (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .column        (column),
    .row           (row),
    .chance        (chance),
    .load_slope    (load_slope),
    .load_disorder (load_disorder),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .site_slope    (site_slope),
    .site_disorder (site_disorder),
    .did_flip      (did_flip),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block wedges and a handshake never completes
  initial begin
    #5_000_000;
    $display("** kpz_single_step_site_update_core: FAILED **");
    $finish;
  end

  // Receiver: stall on a pattern of its own. Switch between styles in
  // segments of random length, including segments with no stall at all.
  // When the stimulus asks for a hold-off, keep stall high for a long count
  // so the result register fills and the block has to stall its input.
  initial begin : result_receiver
    int unsigned seg_left;
    int unsigned seg_style;
    int unsigned hold_left;
    seg_left      = 0;
    seg_style     = 0;
    hold_left     = 0;
    hold_off_done = 0;
    out_stall     = 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_style = $urandom_range(0, 3);
        seg_left  = $urandom_range(16, 160);
      end
      seg_left--;
      if (hold_off_asks != hold_off_done) begin
        hold_off_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (seg_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          2:       out_stall <= (seg_left % 4 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Offer one word and hold it until taken. Bursts of random length are
  // separated by random gaps; a gap of zero gives back-to-back bursts.
  // Return at the accepting edge so the caller can drive the next word
  // in the same step without dropping valid.
  task automatic send_word(input logic [REQ_W-1:0] rq, input logic [SITE_BITS-1:0] site,
                           input logic [CHANCE_W-1:0] ch, input logic ls, input logic ld);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    req_type      <= rq;
    column        <= site[COLUMN_BITS-1:0];
    row           <= site[SITE_BITS-1:COLUMN_BITS];
    chance        <= ch;
    load_slope    <= ls;
    load_disorder <= ld;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Write both bits of a site and remember that it may now be read
  task automatic load_site(input logic [SITE_BITS-1:0] site, input logic ls, input logic ld);
    send_word(kpzss_pkg::REQ_LOAD, site, CHANCE_W'($urandom), ls, ld);
    if (!site_loaded[site]) begin
      site_loaded[site] = 1'b1;
      loaded_sites.push_back(site);
    end
  endtask

  // Mostly uniform, with the ends of the range and the values either side
  // of a live probability threshold mixed in
  function automatic logic [CHANCE_W-1:0] pick_chance();
    logic [PROB_W-1:0] thresh;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: begin
        case ($urandom_range(0, 3))
          0:       thresh = lattice_settings.p_zero;
          1:       thresh = lattice_settings.q_zero;
          2:       thresh = lattice_settings.p_one;
          default: thresh = lattice_settings.q_one;
        endcase
        if (thresh >= PROB_ALWAYS) return '1;
        if (thresh == PROB_NEVER) return '0;
        return thresh[CHANCE_W-1:0] - CHANCE_W'($urandom_range(0, 1));
      end
      default: return CHANCE_W'($urandom);
    endcase
  endfunction

  function automatic logic [PROB_W-1:0] rand_prob();
    case ($urandom_range(0, 7))
      0:       return PROB_NEVER;
      1:       return PROB_ALWAYS;
      default: return PROB_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Load a short run of a row (sometimes across the wrap) and then hammer it
  // with update attempts, so that pairs keep flipping back and forth
  task automatic work_window();
    logic [ROW_BITS-1:0]    rw;
    logic [COLUMN_BITS-1:0] c0;
    logic [COLUMN_BITS-1:0] cc;
    int unsigned            len;
    int unsigned            tries;
    logic [SITE_BITS-1:0]   site;
    rw  = ROW_BITS'($urandom);
    c0  = ($urandom_range(0, 3) == 0) ? COLUMN_BITS'($urandom_range(1018, 1023))
                                      : COLUMN_BITS'($urandom);
    len = $urandom_range(2, 6);
    for (int k = 0; k <= len; k++) begin
      cc   = c0 + COLUMN_BITS'(k);
      site = {rw, cc};
      // refresh an already loaded site now and then to reshuffle the pairs
      if (!site_loaded[site] || $urandom_range(0, 3) == 0)
        load_site(site, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    tries = $urandom_range(4, 16);
    repeat (tries) begin
      cc   = c0 + COLUMN_BITS'($urandom_range(0, len - 1));
      site = {rw, cc};
      if ($urandom_range(0, 5) == 0)
        send_word(kpzss_pkg::REQ_READ, site, pick_chance(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_word(kpzss_pkg::REQ_UPDATE, site, pick_chance(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  // Random traffic: mostly windows of loads followed by update attempts,
  // with stray loads anywhere in the lattice and reads and updates of loaded sites
  task automatic run_sites(input int unsigned count);
    int unsigned          target;
    int unsigned          pick;
    logic [SITE_BITS-1:0] site;
    logic [SITE_BITS-1:0] site_right;
    target = words_sent + count;
    while (words_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        load_site(SITE_BITS'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick <= 2 && loaded_sites.size() != 0) begin
        site       = loaded_sites[$urandom_range(0, loaded_sites.size() - 1)];
        site_right = {site[SITE_BITS-1:COLUMN_BITS],
                      site[COLUMN_BITS-1:0] + COLUMN_BITS'(1)};
        // never attempt an update whose right neighbour holds nothing yet
        if (pick == 1 && site_loaded[site_right])
          send_word(kpzss_pkg::REQ_UPDATE, site, pick_chance(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          send_word(($urandom_range(0, 4) == 0) ? REQ_UNKNOWN : kpzss_pkg::REQ_READ, site,
                    pick_chance(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        work_window();
      end
    end
  endtask

  // Drop valid and wait until every word owed by the block has come back
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write every register, back to back, while the block is idle
  task automatic set_lattice_config(input logic [MODE_W-1:0] mode,
                                    input logic [PROB_W-1:0] p0, input logic [PROB_W-1:0] q0,
                                    input logic [PROB_W-1:0] p1, input logic [PROB_W-1:0] q1);
    cfg_wr_en <= 1'b1;
    cfg_index <= kpzss_pkg::CFG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= kpzss_pkg::CFG_P_ZERO;
    cfg_data  <= p0;
    @(posedge clk);
    cfg_index <= kpzss_pkg::CFG_Q_ZERO;
    cfg_data  <= q0;
    @(posedge clk);
    cfg_index <= kpzss_pkg::CFG_P_ONE;
    cfg_data  <= p1;
    @(posedge clk);
    cfg_index <= kpzss_pkg::CFG_Q_ONE;
    cfg_data  <= q1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lattice_settings = '{mode: mode, p_zero: p0, q_zero: q0, p_one: p1, q_one: q1};
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = kpzss_pkg::CFG_MODE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = kpzss_pkg::REQ_READ;
    column        = '0;
    row           = '0;
    chance        = '0;
    load_slope    = 1'b0;
    load_disorder = 1'b0;
    words_sent    = 0;
    burst_left    = 0;
    hold_off_asks = 0;
    lattice_settings = '{mode: kpzss_pkg::MODE_RESET, p_zero: kpzss_pkg::PROB_RESET,
                         q_zero: kpzss_pkg::PROB_RESET, p_one: kpzss_pkg::PROB_RESET,
                         q_one: kpzss_pkg::PROB_RESET};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings (plain mode).
    // A 0,1 pair flips whatever the chance; the reverse pair never does.
    load_site({6'd0, 10'd0}, 1'b0, 1'b0);
    load_site({6'd0, 10'd1}, 1'b1, 1'b1);
    send_word(kpzss_pkg::REQ_UPDATE, {6'd0, 10'd0}, 16'h0000, 1'b0, 1'b0);
    send_word(kpzss_pkg::REQ_READ,   {6'd0, 10'd0}, 16'h0000, 1'b0, 1'b0);
    send_word(kpzss_pkg::REQ_UPDATE, {6'd0, 10'd0}, 16'hFFFF, 1'b1, 1'b1);
    // Neighbour of the last column wraps to column zero of the same row
    load_site({6'd63, 10'd1023}, 1'b0, 1'b1);
    load_site({6'd63, 10'd0},    1'b1, 1'b0);
    send_word(kpzss_pkg::REQ_UPDATE, {6'd63, 10'd1023}, 16'hFFFF, 1'b1, 1'b1);
    send_word(REQ_UNKNOWN, {6'd63, 10'd0}, 16'h5555, 1'b1, 1'b0);
    send_word(kpzss_pkg::REQ_READ,   {6'd63, 10'd1023}, 16'hAAAA, 1'b0, 1'b1);
    // Alternating coordinate bits in both senses
    load_site({6'b101010, 10'b1010101010}, 1'b1, 1'b1);
    load_site({6'b010101, 10'b0101010101}, 1'b0, 1'b0);
    send_word(kpzss_pkg::REQ_READ, {6'b101010, 10'b1010101010}, 16'h0000, 1'b0, 1'b0);
    run_sites(PHASE_WORDS);
    drain_words();

    // PQ mode at the extremes: 0,1 pairs always flip, 1,0 pairs never
    set_lattice_config(MODE_PQ, PROB_ALWAYS, PROB_NEVER, PROB_ALWAYS, PROB_ALWAYS);
    run_sites(PHASE_WORDS);
    drain_words();

    // The reverse, with a long receiver hold-off while the sender keeps going
    set_lattice_config(MODE_PQ, PROB_NEVER, PROB_ALWAYS, PROB_NEVER, PROB_NEVER);
    hold_off_asks <= hold_off_asks + 1;
    run_sites(PHASE_WORDS);
    drain_words();

    // Disorder mode; an over-range probability must behave as always
    set_lattice_config(MODE_DISORDER, 17'd32768, 17'd16384, PROB_HUGE, PROB_NEVER);
    run_sites(PHASE_WORDS);
    drain_words();

    // Undefined mode code decodes as disorder mode
    set_lattice_config(MODE_UNKNOWN, rand_prob(), rand_prob(), rand_prob(), rand_prob());
    run_sites(PHASE_WORDS);
    drain_words();

    set_lattice_config(MODE_DISORDER, rand_prob(), rand_prob(), rand_prob(), rand_prob());
    hold_off_asks <= hold_off_asks + 1;
    run_sites(PHASE_WORDS);
    drain_words();

    // Thresholds one step from either end of the chance range
    set_lattice_config(MODE_PQ, 17'd1, 17'd65535, 17'd1, 17'd65535);
    run_sites(PHASE_WORDS);
    drain_words();

    // Back to plain mode with arbitrary probabilities, which must be ignored
    set_lattice_config(kpzss_pkg::MODE_PLAIN, rand_prob(), rand_prob(), rand_prob(),
                       rand_prob());
    run_sites(PHASE_WORDS);
    drain_words();

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("** kpz_single_step_site_update_core: PASSED **");
    end else begin
      $display("** kpz_single_step_site_update_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: kpz_single_step_site_update_core.f
hw/rtl/kpzss_pkg.sv
hw/rtl/kpzss_bit_ram.sv
hw/rtl/kpzss_flip_rule.sv
hw/rtl/kpz_single_step_site_update_core.sv
test/kpz_site_word_checker.sv
test/tb_kpz_single_step_site_update_core.sv
